// File: rtl/assert_macros.svh
// assertion helpers, clocked and gated by an active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/smcs_pkg.sv
package smcs_pkg;

    localparam int VEL_W     = 26;
    localparam int TICK_W    = 32;
    localparam int ACC_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_QUEUE_DEPTH  = 32;
    localparam int DEF_STEP_BIT_POS = 24;

    // input function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ENQ  = 1'b1;

    // enqueue kind codes at the port
    localparam logic [1:0] CMD_MOVE  = 2'd0;
    localparam logic [1:0] CMD_DWELL = 2'd1;
    localparam logic [1:0] CMD_PEN   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_UP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_DOWN = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_MOVE,
        KIND_DWELL,
        KIND_PEN
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic [TICK_W-1:0]        ticks;
        logic                     pen;
    } t_cmd;

    typedef struct packed {
        logic enq;
        t_cmd cmd;
    } t_item;

    typedef struct packed {
        logic step_x;
        logic step_y;
        logic dir_x;
        logic dir_y;
        logic pen_a;
        logic pen_b;
        logic pen_pwr;
    } t_pins;

    typedef struct packed {
        logic  accepted;
        logic  empty;
        logic  room;
        logic  busy;
        t_pins pins;
    } t_result;

endpackage

// File: rtl/smcs_front.sv
module smcs_front
    import smcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_func,
    input  logic [1:0]           i_cmd_kind,
    input  logic [VEL_W-1:0]     i_vel_x,
    input  logic [VEL_W-1:0]     i_vel_y,
    input  logic [TICK_W-1:0]    i_duration,
    input  logic                 i_pen_up,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_busy,
    output logic                 o_valid,
    output t_item                o_item
);

    logic [TICK_W-1:0] r_pen_up_ticks;
    logic [TICK_W-1:0] r_pen_down_ticks;

    t_item      r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    t_item cls;
    logic  push;
    logic  pop;

    // decode the beat into the stored command form
    always_comb begin
        cls           = '0;
        cls.enq       = (i_func == FUNC_ENQ);
        cls.cmd.kind  = KIND_NONE;
        if (i_func == FUNC_ENQ) begin
            case (i_cmd_kind)
                CMD_MOVE: begin
                    cls.cmd.kind  = KIND_MOVE;
                    cls.cmd.vel_x = i_vel_x;
                    cls.cmd.vel_y = i_vel_y;
                    cls.cmd.ticks = i_duration;
                end
                CMD_DWELL: begin
                    cls.cmd.kind  = KIND_DWELL;
                    cls.cmd.ticks = i_duration;
                end
                CMD_PEN: begin
                    cls.cmd.kind  = KIND_PEN;
                    cls.cmd.pen   = i_pen_up;
                    cls.cmd.ticks = i_pen_up ? r_pen_up_ticks : r_pen_down_ticks;
                end
                default: begin
                    cls.cmd.kind  = KIND_NONE;
                end
            endcase
        end
    end

    assign o_busy  = (r_cnt == 2'd2);
    assign push    = i_start && !o_busy;
    assign pop     = (r_cnt != 2'd0);
    assign o_valid = pop;
    assign o_item  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_up_ticks   <= '0;
            r_pen_down_ticks <= '0;
            r_wr_ptr         <= 1'b0;
            r_rd_ptr         <= 1'b0;
            r_cnt            <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PEN_UP:   r_pen_up_ticks   <= i_cfg_data;
                    CFG_PEN_DOWN: r_pen_down_ticks <= i_cfg_data;
                    default:      r_pen_up_ticks   <= r_pen_up_ticks;
                endcase
            end
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

// File: rtl/smcs_back.sv
`include "assert_macros.svh"

module smcs_back
    import smcs_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int STEP_BIT_POS = DEF_STEP_BIT_POS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_done,
    output t_result o_result
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // idle command and line levels after reset (dir lines high)
    localparam t_cmd  CMD_IDLE   = '{kind: KIND_NONE, vel_x: '0, vel_y: '0,
                                     ticks: '0, pen: 1'b0};
    localparam t_pins PINS_RESET = '{step_x: 1'b0, step_y: 1'b0, dir_x: 1'b1,
                                     dir_y: 1'b1, pen_a: 1'b0, pen_b: 1'b0,
                                     pen_pwr: 1'b0};

    t_cmd              r_mem [QUEUE_DEPTH];
    t_cmd              r_rdata;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    t_cmd              r_cur, n_cur;
    logic [ACC_W-1:0]  r_acc_x, n_acc_x;
    logic [ACC_W-1:0]  r_acc_y, n_acc_y;
    t_pins             r_pins, n_pins;
    logic              r_accepted, n_accepted;
    logic              r_done;

    logic mem_we;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [ACC_W-1:0] sext(input logic [VEL_W-1:0] v);
        sext = {{(ACC_W - VEL_W){v[VEL_W-1]}}, v};
    endfunction

    function automatic logic positive(input logic [VEL_W-1:0] v);
        positive = !v[VEL_W-1] && (v != '0);
    endfunction

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_cur      = r_cur;
        n_acc_x    = r_acc_x;
        n_acc_y    = r_acc_y;
        n_pins     = r_pins;
        n_accepted = 1'b0;
        mem_we     = 1'b0;
        if (i_valid) begin
            if (i_item.enq) begin
                // unknown kinds arrive as none and are dropped
                if (i_item.cmd.kind != KIND_NONE && r_count != FULL_CNT) begin
                    mem_we     = 1'b1;
                    n_tail     = ptr_inc(r_tail);
                    n_count    = r_count + CNT_W'(1);
                    n_accepted = 1'b1;
                end
            end else if (r_cur.kind == KIND_NONE || r_cur.ticks == '0) begin
                // fetch: restore idle pen power after a pen command
                if (r_cur.kind == KIND_PEN) begin
                    n_pins.pen_pwr = !r_cur.pen;
                end
                if (r_count != '0) begin
                    n_cur   = r_rdata;
                    n_head  = ptr_inc(r_head);
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_cur      = '0;
                    n_cur.kind = KIND_NONE;
                end
                if (n_cur.kind == KIND_PEN) begin
                    n_pins.pen_a   = n_cur.pen;
                    n_pins.pen_b   = !n_cur.pen;
                    n_pins.pen_pwr = 1'b1;
                end
            end else begin
                if (r_cur.kind == KIND_MOVE) begin
                    n_acc_x       = r_acc_x + sext(r_cur.vel_x);
                    n_acc_y       = r_acc_y + sext(r_cur.vel_y);
                    n_pins.dir_x  = positive(r_cur.vel_x);
                    n_pins.dir_y  = positive(r_cur.vel_y);
                    n_pins.step_x = n_acc_x[STEP_BIT_POS];
                    n_pins.step_y = n_acc_y[STEP_BIT_POS];
                end
                n_cur.ticks = r_cur.ticks - TICK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_cur       <= CMD_IDLE;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_pins      <= PINS_RESET;
            r_accepted  <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_cur      <= n_cur;
            r_acc_x    <= n_acc_x;
            r_acc_y    <= n_acc_y;
            r_pins     <= n_pins;
            r_accepted <= n_accepted;
            r_done     <= i_valid;
        end
    end

    // command memory, read data always tracks the next head entry
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= i_item.cmd;
        end
        if (mem_we && r_tail == n_head) begin
            r_rdata <= i_item.cmd;
        end else begin
            r_rdata <= r_mem[n_head];
        end
    end

    assign o_done            = r_done;
    assign o_result.accepted = r_accepted;
    assign o_result.empty    = (r_count == '0);
    assign o_result.room     = (r_count != FULL_CNT);
    assign o_result.busy     = (r_cur.kind != KIND_NONE);
    assign o_result.pins     = r_pins;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT)
    `ASSERT_IMPLIES(a_empty_ptrs, i_clk, i_rst_n, r_count == '0, r_head == r_tail)
    `ASSERT_IMPLIES(a_part_ptrs, i_clk, i_rst_n, r_count != '0 && r_count != FULL_CNT, r_head != r_tail)
    `ASSERT_IMPLIES(a_none_idle, i_clk, i_rst_n, r_cur.kind == KIND_NONE, r_cur.ticks == '0)

endmodule

// File: rtl/stepper_motion_command_sequencer_core.sv
// two-axis plotter motion sequencer. a beat with i_func high enqueues a move, dwell or pen
// command into a QUEUE_DEPTH-entry command memory (a full memory or an unknown kind drops it,
// o_accepted low); a beat with i_func low is one timer tick that either fetches the next
// command or advances the current one, stepping the axes from the STEP_BIT_POS bit of two
// free-running 32-bit accumulators. beats are taken whenever start is high and busy is
// low, one per clock. every beat gives exactly one result, shown for one cycle with o_done
// after passing the front queue register and the back-end result register; the receiver cannot
// hold results off, so they must be taken as they come. the rate of one beat per clock is set
// by the back-end execute stage, whose registered command memory read tracks the next head.
// pen durations come from the config registers at the moment a pen command is enqueued;
// write them only while no beat is in flight. no clearing pass runs after reset.
`include "assert_macros.svh"

module stepper_motion_command_sequencer_core
    import smcs_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int STEP_BIT_POS = DEF_STEP_BIT_POS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_func,
    input  logic [1:0]           i_cmd_kind,
    input  logic [VEL_W-1:0]     i_vel_x,
    input  logic [VEL_W-1:0]     i_vel_y,
    input  logic [TICK_W-1:0]    i_duration,
    input  logic                 i_pen_up,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // result channel
    output logic                 o_done,
    output logic                 o_accepted,
    output logic                 o_queue_empty,
    output logic                 o_queue_has_room,
    output logic                 o_busy_res,
    output logic                 o_step_x,
    output logic                 o_step_y,
    output logic                 o_dir_x,
    output logic                 o_dir_y,
    output logic                 o_pen_a,
    output logic                 o_pen_b,
    output logic                 o_pen_power
);

    logic    q_valid;
    t_item   q_item;
    t_result res;

    // front: decode beats, latch pen durations, buffer in a short queue
    smcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_func     (i_func),
        .i_cmd_kind (i_cmd_kind),
        .i_vel_x    (i_vel_x),
        .i_vel_y    (i_vel_y),
        .i_duration (i_duration),
        .i_pen_up   (i_pen_up),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_busy     (busy),
        .o_valid    (q_valid),
        .o_item     (q_item)
    );

    // back: command memory, current command, accumulators and line levels
    smcs_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .STEP_BIT_POS (STEP_BIT_POS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_done   (o_done),
        .o_result (res)
    );

    assign o_accepted       = res.accepted;
    assign o_queue_empty    = res.empty;
    assign o_queue_has_room = res.room;
    assign o_busy_res       = res.busy;
    assign o_step_x         = res.pins.step_x;
    assign o_step_y         = res.pins.step_y;
    assign o_dir_x          = res.pins.dir_x;
    assign o_dir_y          = res.pins.dir_y;
    assign o_pen_a          = res.pins.pen_a;
    assign o_pen_b          = res.pins.pen_b;
    assign o_pen_power      = res.pins.pen_pwr;

    // every accepted beat surfaces as a result through the front queue and back-end registers
    `ASSERT_IMPLIES(a_beat_latency, i_clk, i_rst_n, start && !busy, ##2 o_done)

endmodule
